// ===== design/tocf_pkg.sv =====
// Shared types, constants and helpers for the third-order complementary filter.
// Used by tocf_ctrl, tocf_dp and the top level third_order_complementary_filter.
package tocf_pkg;

	localparam int unsigned StateW = 32;   // Q16.16 estimates and samples
	localparam int unsigned GainW  = 16;   // Q8.8 gains
	localparam int unsigned TsW    = 16;   // Q0.16 step length
	localparam int unsigned ErrW   = StateW + 1;
	localparam int unsigned MulAW  = 42;   // rate rounded to Q16.16, or error extended
	localparam int unsigned MulBW  = TsW + 1;
	localparam int unsigned ProdW  = MulAW + MulBW;
	localparam int unsigned Rate24W = 50;
	localparam int unsigned IncW   = ProdW - 16;
	localparam int unsigned SumW   = IncW + 1;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [GainW-1:0]  GainK1Reset = 16'sd2304;
	localparam logic [GainW-1:0]  GainK2Reset = 16'sd6912;
	localparam logic [GainW-1:0]  GainK3Reset = -16'sd6912;
	localparam logic [TsW-1:0]    TimeStepReset = 16'd655;
	localparam logic [StateW-1:0] InitReset = '0;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_GAIN_K1   = 3'd0,
		CFG_GAIN_K2   = 3'd1,
		CFG_GAIN_K3   = 3'd2,
		CFG_TIME_STEP = 3'd3,
		CFG_INIT_POS  = 3'd4,
		CFG_INIT_VEL  = 3'd5,
		CFG_INIT_BIAS = 3'd6
	} cfg_idx_t;

	// Which estimate is being advanced.
	typedef enum logic [1:0] {
		TERM_POS  = 2'd0,
		TERM_VEL  = 2'd1,
		TERM_BIAS = 2'd2
	} term_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_GAIN,
		ST_RATE,
		ST_MUL_STEP,
		ST_UPDATE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  in_load;    // capture an input transfer into the buffer
		logic  err_load;   // form position error and corrected acceleration
		logic  mul_en;     // run the shared multiplier
		logic  mul_step;   // 1: rate times step, 0: gain times error
		logic  rate_en;    // form the rate and round it to Q16.16
		logic  upd_en;     // add the increment to the selected estimate
		term_t term;
	} cmd_t;

	function automatic logic [StateW-1:0] sat32(input logic signed [SumW-1:0] x);
		logic signed [SumW-1:0] hi;
		logic signed [SumW-1:0] lo;
		hi = SumW'(signed'({1'b0, {(StateW-1){1'b1}}}));
		lo = -hi - SumW'(1);
		if (x > hi)
			sat32 = {1'b0, {(StateW-1){1'b1}}};
		else if (x < lo)
			sat32 = {1'b1, {(StateW-1){1'b0}}};
		else
			sat32 = x[StateW-1:0];
	endfunction

endpackage

// ===== design/tocf_ctrl.sv =====
// Sequencing state machine for the third-order complementary filter.
// Depends on tocf_pkg; drives the command struct of tocf_dp.
module tocf_ctrl
	import tocf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	term_t  term_q;
	logic   in_full_q;
	logic   out_valid_q;
	logic   in_xfer;
	logic   last_term;

	assign in_xfer   = s_tvalid && s_tready;
	assign s_tready  = !in_full_q;
	assign m_tvalid  = out_valid_q;
	assign last_term = (term_q == TERM_BIAS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_full_q && !out_valid_q) state_d = ST_ERR;
			ST_ERR:      state_d = ST_MUL_GAIN;
			ST_MUL_GAIN: state_d = ST_RATE;
			ST_RATE:     state_d = ST_MUL_STEP;
			ST_MUL_STEP: state_d = ST_UPDATE;
			ST_UPDATE:   state_d = last_term ? ST_IDLE : ST_MUL_GAIN;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.in_load  = in_xfer;
		cmd.term     = term_q;
		unique case (state_q)
			ST_ERR:      cmd.err_load = 1'b1;
			ST_MUL_GAIN: cmd.mul_en = 1'b1;
			ST_RATE:     cmd.rate_en = 1'b1;
			ST_MUL_STEP: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = 1'b1;
			end
			ST_UPDATE:   cmd.upd_en = 1'b1;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			term_q      <= TERM_POS;
			in_full_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ERR)
				term_q <= TERM_POS;
			else if (state_q == ST_UPDATE && !last_term)
				term_q <= term_t'(term_q + 2'd1);
			if (in_xfer)
				in_full_q <= 1'b1;
			else if (state_q == ST_ERR)
				in_full_q <= 1'b0;
			if (state_q == ST_UPDATE && last_term)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/tocf_dp.sv =====
// Datapath of the third-order complementary filter: settings, estimates and
// one shared multiplier. Depends on tocf_pkg; steered by tocf_ctrl.
module tocf_dp
	import tocf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [2*StateW-1:0] in_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [StateW-1:0]   cfg_data,
	output logic [StateW-1:0]   pos,
	output logic [StateW-1:0]   vel,
	output logic [StateW-1:0]   bias
);

	logic signed [GainW-1:0]  gain_k1_q, gain_k2_q, gain_k3_q;
	logic [TsW-1:0]           time_step_q;
	logic signed [StateW-1:0] init_pos_q, init_vel_q, init_bias_q;
	logic signed [StateW-1:0] pos_q, vel_q, bias_q;
	logic signed [StateW-1:0] acc_buf_q, meas_buf_q;
	logic signed [ErrW-1:0]   err_q, accb_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [MulAW-1:0]  rate16_q;

	logic signed [MulAW-1:0]   mul_a;
	logic signed [MulBW-1:0]   mul_b;
	logic signed [GainW-1:0]   gain_sel;
	logic signed [Rate24W-1:0] base24, rate24, rate24_rnd;
	logic signed [ProdW-1:0]   prod_rnd;
	logic signed [IncW-1:0]    inc;
	logic signed [StateW-1:0]  cur;
	logic signed [SumW-1:0]    sum;
	logic [StateW-1:0]         upd_val;
	logic                      reload;

	assign pos  = pos_q;
	assign vel  = vel_q;
	assign bias = bias_q;

	always_comb begin
		case (cmd.term)
			TERM_POS: begin
				gain_sel = gain_k1_q;
				base24   = Rate24W'(vel_q) <<< 8;
				cur      = pos_q;
			end
			TERM_VEL: begin
				gain_sel = gain_k2_q;
				base24   = Rate24W'(accb_q) <<< 8;
				cur      = vel_q;
			end
			default: begin
				gain_sel = gain_k3_q;
				base24   = '0;
				cur      = bias_q;
			end
		endcase
	end

	// Shared multiplier: gain times error, then rounded rate times step.
	always_comb begin
		if (cmd.mul_step) begin
			mul_a = rate16_q;
			mul_b = MulBW'(signed'({1'b0, time_step_q}));
		end else begin
			mul_a = MulAW'(err_q);
			mul_b = MulBW'(gain_sel);
		end
	end

	assign rate24     = base24 + prod_q[Rate24W-1:0];
	assign rate24_rnd = rate24 + Rate24W'(128);
	assign prod_rnd   = prod_q + ProdW'(32768);
	assign inc        = prod_rnd[ProdW-1:16];
	assign sum        = SumW'(cur) + SumW'(inc);
	assign upd_val    = sat32(sum);
	assign reload     = cfg_we && (cfg_index == CFG_INIT_POS || cfg_index == CFG_INIT_VEL
		|| cfg_index == CFG_INIT_BIAS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_k1_q   <= GainK1Reset;
			gain_k2_q   <= GainK2Reset;
			gain_k3_q   <= GainK3Reset;
			time_step_q <= TimeStepReset;
			init_pos_q  <= InitReset;
			init_vel_q  <= InitReset;
			init_bias_q <= InitReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_K1:   gain_k1_q   <= cfg_data[GainW-1:0];
				CFG_GAIN_K2:   gain_k2_q   <= cfg_data[GainW-1:0];
				CFG_GAIN_K3:   gain_k3_q   <= cfg_data[GainW-1:0];
				CFG_TIME_STEP: time_step_q <= cfg_data[TsW-1:0];
				CFG_INIT_POS:  init_pos_q  <= cfg_data;
				CFG_INIT_VEL:  init_vel_q  <= cfg_data;
				CFG_INIT_BIAS: init_bias_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Estimates reload from the init values at reset and on any init write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= InitReset;
			vel_q  <= InitReset;
			bias_q <= InitReset;
		end else if (reload) begin
			pos_q  <= (cfg_index == CFG_INIT_POS)  ? cfg_data : init_pos_q;
			vel_q  <= (cfg_index == CFG_INIT_VEL)  ? cfg_data : init_vel_q;
			bias_q <= (cfg_index == CFG_INIT_BIAS) ? cfg_data : init_bias_q;
		end else if (cmd.upd_en) begin
			case (cmd.term)
				TERM_POS: pos_q  <= upd_val;
				TERM_VEL: vel_q  <= upd_val;
				default:  bias_q <= upd_val;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			acc_buf_q  <= in_data[StateW-1:0];
			meas_buf_q <= in_data[2*StateW-1:StateW];
		end
		if (cmd.err_load) begin
			err_q  <= ErrW'(meas_buf_q) - ErrW'(pos_q);
			accb_q <= ErrW'(acc_buf_q) - ErrW'(bias_q);
		end
		if (cmd.mul_en)
			prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
		if (cmd.rate_en)
			rate16_q <= rate24_rnd[Rate24W-1:8];
	end

endmodule

// ===== design/third_order_complementary_filter.sv =====
// Top level of the third-order complementary filter with bias estimation.
// Depends on tocf_pkg and instantiates tocf_ctrl and tocf_dp.
//
// Usage: each transfer on the slave stream carries one acceleration sample and
// one position measurement, both signed Q16.16. For each transfer the block
// advances its position, velocity and accelerometer bias estimates by one
// Euler step and offers the three updated estimates as one transfer on the
// master stream, saturated to the Q16.16 range.
// The configuration port writes the three gains (Q8.8), the step length (Q0.16)
// and the three initial estimates. Writing any initial estimate reloads all
// three estimates; writes must happen only while the block is idle.
// Sequence: an accepted sample waits in a one-entry input buffer; the
// sequencer then forms the position error and, for each estimate in turn,
// the gain product, rate rounding, step product and update, all through a
// single shared 42 x 17 bit multiplier. m_tvalid rises after the update of
// the bias estimate. The sequencer leaves idle only after the last result is
// taken, so a new sample starts processing only once no result is waiting.
// The input buffer accepts the next sample while a result still waits on the
// master side; a stalled receiver holds the result and blocks further updates
// until it is taken. Reset loads the default gains and step, zeroes estimates.
module third_order_complementary_filter
	import tocf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2*StateW-1:0] s_tdata,   // acceleration, measured_position
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [3*StateW-1:0] m_tdata,   // est_position, est_velocity, est_bias
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [StateW-1:0]   cfg_data
);

	cmd_t              cmd;
	logic [StateW-1:0] pos, vel, bias;

	tocf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tocf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos       (pos),
		.vel       (vel),
		.bias      (bias)
	);

	// The estimates themselves form the result; the sequencer updates them only after the
	// result has been taken.
	assign m_tdata = {bias, vel, pos};

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for third_order_complementary_filter: a stream driver, a
// stream monitor and a bit-exact predictor of the estimator, all in one module.
// Depends on tocf_pkg for the register index codes and the port widths.
module testbench;
	import tocf_pkg::*;

	// Q16.16 extremes and the one register index that maps to nothing.
	localparam logic [StateW-1:0]  QMax       = 32'h7FFF_FFFF;
	localparam logic [StateW-1:0]  QMin       = 32'h8000_0000;
	localparam logic [CfgIdxW-1:0] CfgUnused  = 3'd7;
	// Cycles without any transfer before the run is declared hung.
	localparam int                 StallLimit = 2000;
	localparam int                 DrainWait  = 40;

	// One result transfer; the last field sits in the lowest bits of tdata.
	typedef struct packed {
		logic signed [StateW-1:0] bias;
		logic signed [StateW-1:0] vel;
		logic signed [StateW-1:0] pos;
	} est_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [2*StateW-1:0] s_tdata = '0;   // acceleration, measured_position
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [3*StateW-1:0] m_tdata;        // est_position, est_velocity, est_bias
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [StateW-1:0]   cfg_data = '0;

	// Samples waiting to be offered, and estimates waiting to come out.
	logic [2*StateW-1:0] pending_samples[$];
	est_t                expected_estimates[$];

	int mismatches = 0;
	int idle_cycles = 0;
	int src_gap = 0;
	int sink_gap = 0;
	bit steady_flow = 1'b0;  // when set, neither side inserts idle cycles

	// Predictor copy of the register file and of the three estimates.
	logic signed [GainW-1:0]  gain_k1, gain_k2, gain_k3;
	logic        [TsW-1:0]    step_len;
	logic signed [StateW-1:0] init_pos, init_vel, init_bias;
	logic signed [StateW-1:0] pos_est, vel_est, bias_est;

	// Synthetic trajectory that the well-behaved samples follow.
	longint track_pos = 0;
	longint track_vel = 0;

	third_order_complementary_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Round to nearest with ties upward: add half an LSB, then floor-shift.
	// The arithmetic shift of a signed 64-bit value is exactly the floor.
	function automatic longint round_shift(input longint x, input int n);
		round_shift = (x + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic logic [StateW-1:0] clamp_q16(input longint x);
		if (x > longint'(2147483647))
			clamp_q16 = QMax;
		else if (x < -(longint'(1) <<< 31))
			clamp_q16 = QMin;
		else
			clamp_q16 = x[StateW-1:0];
	endfunction

	// One Euler step of the filter. The three rates are formed at Q.24 from
	// the estimates held before the step, rounded to Q16.16, scaled by the step
	// length and rounded again; each sum saturates to the Q16.16 range.
	function automatic est_t advance_estimates(input logic signed [StateW-1:0] accel,
			input logic signed [StateW-1:0] meas);
		longint err, rate_p, rate_v, rate_b, dt;
		est_t   next;
		dt     = longint'(step_len);
		err    = longint'(meas) - longint'(pos_est);
		rate_p = longint'(vel_est) * 256 + longint'(gain_k1) * err;
		rate_v = (longint'(accel) - longint'(bias_est)) * 256 + longint'(gain_k2) * err;
		rate_b = longint'(gain_k3) * err;
		next.pos  = clamp_q16(longint'(pos_est) + round_shift(round_shift(rate_p, 8) * dt, 16));
		next.vel  = clamp_q16(longint'(vel_est) + round_shift(round_shift(rate_v, 8) * dt, 16));
		next.bias = clamp_q16(longint'(bias_est) + round_shift(round_shift(rate_b, 8) * dt, 16));
		pos_est  = next.pos;
		vel_est  = next.vel;
		bias_est = next.bias;
		return next;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Sample driver. The predictor advances at the very edge on which a
	// transfer is accepted, so expectations line up with the block's order.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_estimates.push_back(advance_estimates(s_tdata[StateW-1:0],
					s_tdata[2*StateW-1:StateW]));
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
					// Idle burst; src_gap holds its remaining length.
					src_gap <= $urandom_range(0, 4);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= pending_samples.pop_front();
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// Result monitor: every accepted transfer is checked field by field against
	// the oldest expectation. It also drives the back-pressure and counts
	// cycles without progress for the watchdog.
	always @(posedge clk) begin : result_check
		est_t got;
		est_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_estimates.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want = expected_estimates.pop_front();
					if (got.pos !== want.pos)
						report_mismatch($sformatf("est_position %h, predicted %h",
							got.pos, want.pos));
					if (got.vel !== want.vel)
						report_mismatch($sformatf("est_velocity %h, predicted %h",
							got.vel, want.vel));
					if (got.bias !== want.bias)
						report_mismatch($sformatf("est_bias %h, predicted %h",
							got.bias, want.bias));
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
				sink_gap <= $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= StallLimit);
		$display("timeout: no transfer for %0d cycles", StallLimit);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// A register write takes one clock with the enable high. The predictor
	// takes the write at once; the bench only writes while nothing is in flight.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [StateW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_GAIN_K1:   gain_k1 = data[GainW-1:0];
			CFG_GAIN_K2:   gain_k2 = data[GainW-1:0];
			CFG_GAIN_K3:   gain_k3 = data[GainW-1:0];
			CFG_TIME_STEP: step_len = data[TsW-1:0];
			CFG_INIT_POS:  init_pos = data;
			CFG_INIT_VEL:  init_vel = data;
			CFG_INIT_BIAS: init_bias = data;
			default: ;  // no register behind this index
		endcase
		// Any write to an initial estimate reloads all three estimates.
		if (idx == CFG_INIT_POS || idx == CFG_INIT_VEL || idx == CFG_INIT_BIAS) begin
			pos_est = init_pos;
			vel_est = init_vel;
			bias_est = init_bias;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Block until every queued sample has gone in and every result come out.
	// Each sample yields exactly one result, so the block is idle by then.
	task automatic settle();
		while (pending_samples.size() != 0 || s_tvalid || expected_estimates.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [StateW-1:0] edge_value();
		case ($urandom_range(0, 3))
			0:       edge_value = QMax;
			1:       edge_value = QMin;
			2:       edge_value = '0;
			default: edge_value = '1;
		endcase
	endfunction

	// Register values for the random phases: mostly near a usable tuning,
	// sometimes at the range limits. Gain and step writes carry random upper
	// bits, which the block must ignore.
	function automatic logic [StateW-1:0] random_setting(input logic [CfgIdxW-1:0] idx);
		logic [StateW-1:0] v;
		int                pick;
		v = $urandom();
		pick = $urandom_range(0, 9);
		case (idx)
			CFG_GAIN_K1, CFG_GAIN_K2, CFG_GAIN_K3: begin
				if (pick == 0)
					v[GainW-1:0] = 16'h7FFF;
				else if (pick == 1)
					v[GainW-1:0] = 16'h8000;
				else if (pick == 2)
					v[GainW-1:0] = '0;
				else if (pick < 6)
					v[GainW-1:0] = 16'(int'($urandom_range(0, 20480)) - 10240);
				else if (idx == CFG_GAIN_K1)
					v[GainW-1:0] = 16'(2304 + int'($urandom_range(0, 512)) - 256);
				else if (idx == CFG_GAIN_K2)
					v[GainW-1:0] = 16'(6912 + int'($urandom_range(0, 1024)) - 512);
				else
					v[GainW-1:0] = 16'(-6912 + int'($urandom_range(0, 1024)) - 512);
			end
			CFG_TIME_STEP: begin
				if (pick == 0)
					v[TsW-1:0] = 16'd1;
				else if (pick == 1)
					v[TsW-1:0] = 16'hFFFF;
				else
					v[TsW-1:0] = 16'($urandom_range(64, 4000));
			end
			default: begin
				if (pick < 3)
					v = edge_value();
				else
					v = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
			end
		endcase
		return v;
	endfunction

	// Mostly samples that follow a smooth trajectory so that the estimates
	// track and the filter stays away from its rails; the rest are full-range
	// noise and range extremes that drive the estimates into saturation.
	task automatic queue_random_samples(input int count);
		int                kind;
		logic [StateW-1:0] accel, meas;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				track_vel += longint'(int'($urandom_range(0, 8192)) - 4096);
				if (track_vel > 1 << 20 || track_vel < -(1 << 20))
					track_vel = -track_vel / 2;
				track_pos += track_vel;
				if (track_pos > 1 << 28 || track_pos < -(1 << 28))
					track_pos = 0;
				meas = 32'(track_pos + longint'(int'($urandom_range(0, 2048)) - 1024));
				accel = 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			end else if (kind < 17) begin
				accel = $urandom();
				meas = $urandom();
			end else begin
				accel = edge_value();
				meas = edge_value();
			end
			pending_samples.push_back({meas, accel});
		end
	endtask

	initial begin
		gain_k1 = GainK1Reset;
		gain_k2 = GainK2Reset;
		gain_k3 = GainK3Reset;
		step_len = TimeStepReset;
		init_pos = InitReset;
		init_vel = InitReset;
		init_bias = InitReset;
		pos_est = InitReset;
		vel_est = InitReset;
		bias_est = InitReset;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset tuning with the corner samples of both input fields.
		pending_samples.push_back({32'h0000_0000, 32'h0000_0000});
		pending_samples.push_back({QMax, QMax});
		pending_samples.push_back({QMin, QMin});
		pending_samples.push_back({32'h0000_0001, 32'hFFFF_FFFF});
		pending_samples.push_back({QMin, QMax});
		pending_samples.push_back({QMax, QMin});
		settle();

		// Largest gains and the longest step push the position and velocity estimates
		// onto the positive rail and then onto the negative one, and the bias the other way.
		write_reg(CFG_GAIN_K1, 32'hA5A5_7FFF);
		write_reg(CFG_GAIN_K2, 32'h5A5A_7FFF);
		write_reg(CFG_GAIN_K3, 32'hFFFF_8000);
		write_reg(CFG_TIME_STEP, 32'h0000_FFFF);
		repeat (3) pending_samples.push_back({QMax, QMax});
		repeat (3) pending_samples.push_back({QMin, QMin});
		settle();

		// With a zero step every increment is zero and the estimates hold. The
		// write to the index with no register behind it must change nothing.
		write_reg(CFG_TIME_STEP, 32'h0000_0000);
		write_reg(CfgUnused, 32'hFFFF_FFFF);
		pending_samples.push_back({QMax, 32'h0000_3039});
		pending_samples.push_back({32'hFFFF_FFF9, QMin});
		settle();

		// Loading the initial estimates, two of them at their extremes, then rewriting only
		// one of them, which must reload all three.
		write_reg(CFG_TIME_STEP, 32'h0000_0001);
		write_reg(CFG_INIT_POS, QMax);
		write_reg(CFG_INIT_VEL, QMin);
		write_reg(CFG_INIT_BIAS, 32'hFFFF_FFFF);
		pending_samples.push_back({32'h0000_0000, 32'h0000_0000});
		pending_samples.push_back({QMin, QMax});
		settle();
		write_reg(CFG_INIT_VEL, 32'h0000_0000);
		pending_samples.push_back({32'h0000_0000, QMax});
		pending_samples.push_back({QMin, 32'hFFFF_0000});
		settle();

		// Back to the nominal tuning from a clean start.
		write_reg(CFG_GAIN_K1, 32'(GainK1Reset));
		write_reg(CFG_GAIN_K2, 32'(GainK2Reset));
		write_reg(CFG_GAIN_K3, {16'h0000, GainK3Reset});
		write_reg(CFG_TIME_STEP, 32'(TimeStepReset));
		write_reg(CFG_INIT_POS, 32'h0001_0000);
		write_reg(CFG_INIT_BIAS, 32'h0000_0000);
		pending_samples.push_back({32'h0001_8000, 32'h0000_4000});
		pending_samples.push_back({32'h0002_0000, 32'hFFFF_C000});
		pending_samples.push_back({32'h0001_0000, 32'h0000_0000});
		settle();

		// Random phases, each starting from a fresh random subset of registers.
		// The last phase runs with both sides streaming at full rate.
		for (int phase = 0; phase < 8; phase++) begin
			for (int r = CFG_GAIN_K1; r <= CFG_INIT_BIAS; r++)
				if ($urandom_range(0, 1) == 1)
					write_reg(CfgIdxW'(r), random_setting(CfgIdxW'(r)));
			if ($urandom_range(0, 9) == 0)
				write_reg(CfgUnused, $urandom());
			steady_flow = (phase == 7);
			queue_random_samples(150);
			settle();
		end

		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tocf_pkg.sv
design/tocf_ctrl.sv
design/tocf_dp.sv
design/third_order_complementary_filter.sv
bench/testbench.sv
